// File: hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mts_pkg - shared definitions for the multi-tone sine generator
// Field widths, register map constants and the quarter-wave sine function
// used to build the lookup table at elaboration.
// ============================================================================
package mts_pkg;

    // Field and register widths
    localparam int STEP_W      = 32;
    localparam int AMP_W       = 12;
    localparam int SAMPLE_W    = 17;
    localparam int SINE_W      = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TONE_SEL_W  = 2;

    // Product scaling: Q4.8 * Q1.15 -> units of 2^-10
    localparam int PROD_SHIFT = 13;
    localparam int PROD_W     = 15;
    localparam int FULL_W     = AMP_W + SINE_W + 2;

    // Register map: index = {tone, is_amp}
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_LAST = 3'd5;
    localparam int NUM_CFG_TONES = 3;

    // pi/2 in Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Taylor divisors (2n)(2n+1) for n = 1..12
    localparam int NUM_TERMS = 12;
    localparam logic [63:0] TAYLOR_DIV [NUM_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // (a * b) >> 62, low 64 bits kept
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            return p[125:62];
        end
    endfunction

    // Quarter-wave sine entry k of a table with 2^addr_bits steps, Q1.15
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned addr_bits);
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        int n;
        begin
            frac = 64'(k) << (62 - addr_bits);
            x    = mul_q62(HALF_PI_Q62, frac);
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            for (n = 0; n < NUM_TERMS; n++) begin
                term = mul_q62(term, x2) / TAYLOR_DIV[n];
                if (n % 2 == 0)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            scaled = ((sum >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
            return scaled[SINE_W-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/multi_tone_sine_generator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_tone_sine_generator_unit - direct digital synthesis, several tones
// Per tick word, sums amplitude * sine(phase) over all tones and advances
// each 32-bit phase accumulator by its configured step.
// ============================================================================
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -------------------------------
//  in       sink       in_valid / in_stall    restart
//  out      source     out_valid / out_stall  sample (signed, 2^-10 units)
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One tick word accepted per cycle while in_stall is low; its sample goes
//  through the address, table read, multiply and sum (output) registers in
//  turn, the address loaded at the accepting edge. The table read per
//  tone is the registered ROM port, one per tone lane.
//  Reset zeroes phases, tone registers and valid flags; the table is a constant, no fill time.
//  A 1-word skid after the output register absorbs an output stall; in_stall
//  is that skid's full flag, so it is registered.
//
module multi_tone_sine_generator_unit
    import mts_pkg::*;
#(
    parameter int NUM_TONES      = 3,
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // tick words
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       restart,
    // samples
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    // register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int QUARTER_LEN = 1 << SINE_ADDR_BITS;
    localparam int ADDR_W      = SINE_ADDR_BITS + 1;
    localparam int ROM_BITS    = (QUARTER_LEN + 1) * SINE_W;

    // Packed quarter-wave table, entry k at bits [k*SINE_W +: SINE_W]
    function automatic logic [ROM_BITS-1:0] build_sine_rom();
        logic [ROM_BITS-1:0] rom;
        int k;
        begin
            rom = '0;
            for (k = 0; k <= QUARTER_LEN; k++)
                rom[k*SINE_W +: SINE_W] = sine_entry(k, SINE_ADDR_BITS);
            return rom;
        end
    endfunction

    localparam logic [ROM_BITS-1:0] SINE_ROM = build_sine_rom();

    // Pipeline control
    logic adv;
    logic in_accept;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic signed [SAMPLE_W-1:0] skid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sum_next;

    // Per-tone state
    logic [STEP_W-1:0]         phase_reg    [NUM_TONES];
    logic [STEP_W-1:0]         step_val     [NUM_TONES];
    logic [AMP_W-1:0]          amp_val      [NUM_TONES];
    logic [ADDR_W-1:0]         rom_addr_reg [NUM_TONES];
    logic                      s1_neg_reg   [NUM_TONES];
    logic [SINE_W-1:0]         mag_reg      [NUM_TONES];
    logic                      s2_neg_reg   [NUM_TONES];
    logic signed [PROD_W-1:0]  prod_reg     [NUM_TONES];

    // Config write decode
    logic                   cfg_write;
    logic [TONE_SEL_W-1:0]  cfg_tone;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && (cfg_index <= CFG_INDEX_LAST);
    assign cfg_tone  = cfg_index[CFG_INDEX_W-1:1];

    // Whole pipeline moves while the skid is empty
    assign adv       = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && adv;

    genvar t;
    generate
        for (t = 0; t < NUM_TONES; t++) begin : g_tone
            logic [STEP_W-1:0]           cur_phase;
            logic [SINE_ADDR_BITS-1:0]   quad_k;
            logic [ADDR_W-1:0]           addr_next;
            logic signed [AMP_W:0]       amp_s;
            logic signed [SINE_W:0]      sine_s;
            logic signed [FULL_W-1:0]    full_prod;

            // Step and amplitude registers; a tone beyond the map stays silent
            if (t < NUM_CFG_TONES) begin : g_cfg
                logic [STEP_W-1:0] step_reg;
                logic [AMP_W-1:0]  amp_reg;

                always_ff @(posedge clk or negedge rst_n) begin
                    if (!rst_n) begin
                        step_reg <= '0;
                        amp_reg  <= '0;
                    end
                    else if (cfg_write && cfg_tone == TONE_SEL_W'(t)) begin
                        if (cfg_index[0])
                            amp_reg <= cfg_data[AMP_W-1:0];
                        else
                            step_reg <= cfg_data[STEP_W-1:0];
                    end
                end

                assign step_val[t] = step_reg;
                assign amp_val[t]  = amp_reg;
            end
            else begin : g_nocfg
                assign step_val[t] = '0;
                assign amp_val[t]  = '0;
            end

            // Phase used for this sample, and quarter-wave mirroring
            assign cur_phase = restart ? '0 : phase_reg[t];
            assign quad_k    = cur_phase[STEP_W-3 -: SINE_ADDR_BITS];
            assign addr_next = cur_phase[STEP_W-2]
                             ? (ADDR_W'(QUARTER_LEN) - {1'b0, quad_k})
                             : {1'b0, quad_k};

            // Phase accumulator
            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n)
                    phase_reg[t] <= '0;
                else if (in_accept)
                    phase_reg[t] <= cur_phase + step_val[t];
            end

            // Stage 1: table address and sign
            always_ff @(posedge clk) begin
                if (in_accept) begin
                    rom_addr_reg[t] <= addr_next;
                    s1_neg_reg[t]   <= cur_phase[STEP_W-1];
                end
            end

            // Stage 2: registered table read
            always_ff @(posedge clk) begin
                if (adv) begin
                    mag_reg[t]    <= SINE_ROM[int'(rom_addr_reg[t]) * SINE_W +: SINE_W];
                    s2_neg_reg[t] <= s1_neg_reg[t];
                end
            end

            // Stage 3: amplitude * sine, floored to 2^-10
            assign amp_s     = $signed({1'b0, amp_val[t]});
            assign sine_s    = s2_neg_reg[t] ? -$signed({1'b0, mag_reg[t]})
                                             :  $signed({1'b0, mag_reg[t]});
            assign full_prod = FULL_W'(amp_s * sine_s);

            always_ff @(posedge clk) begin
                if (adv)
                    prod_reg[t] <= full_prod[PROD_SHIFT +: PROD_W];
            end
        end
    endgenerate

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Sum of tone products
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NUM_TONES; i++)
            sum_next = sum_next + SAMPLE_W'(prod_reg[i]);
    end

    // Output register with one-word skid
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_stall) begin
            if (adv && s3_valid_reg)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= adv && s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (out_valid_reg && out_stall) begin
            if (adv && s3_valid_reg)
                skid_reg <= sum_next;
        end
        else if (skid_valid_reg)
            sample_reg <= skid_reg;
        else if (adv && s3_valid_reg)
            sample_reg <= sum_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

`ifndef SYNTHESIS
    // Skid only fills behind a waiting output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output register is empty");

    // A restart tick leaves tone 0 at exactly one step
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && restart) |=> phase_reg[0] == $past(step_val[0]))
        else $error("tone 0 phase wrong after restart");

    // Tone 0 phase moves only on accepted ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall) |=> $stable(phase_reg[0]))
        else $error("tone 0 phase changed without a tick");

    // Pipeline is frozen while the skid is full
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(s3_valid_reg))
        else $error("pipeline advanced while skid full");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the multi-tone sine generator
// Drives tick words with random gaps, stalls the sample side at random, and
// writes the tone registers between phases. Every accepted tick is run
// through a local three-tone synthesizer, and each sample that comes out is
// compared with the oldest sample it predicted. A short directed table opens
// the run; random phases over many register settings follow.
// ============================================================================
module tb_top;
    import mts_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int PIPE_LATENCY    = 4;
    localparam int TONES           = 3;
    localparam int LUT_BITS        = 10;
    localparam int QUARTER         = 1 << LUT_BITS;
    localparam int NUM_PHASES      = 9;
    localparam int TICKS_PER_PHASE = 150;
    localparam int NUM_DIRECTED    = 31;

    // register map, index = {tone, is_amp}
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TONE0_STEP,
        REG_TONE0_AMP,
        REG_TONE1_STEP,
        REG_TONE1_AMP,
        REG_TONE2_STEP,
        REG_TONE2_AMP,
        REG_SPARE6,
        REG_SPARE7
    } reg_index_e;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e                  kind;
        reg_index_e                 idx;
        logic [CFG_DATA_W-1:0]      data;
        logic                       rs;
        logic                       has_exp;
        logic signed [SAMPLE_W-1:0] exp_sample;
    } dir_row_t;

    // Directed table: register writes and tick words. Typed samples use full-scale
    // amplitude at quarter-turn steps, so the sine is 0 or +/-32767.
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // all amplitudes zero after reset
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b1, 17'sd0},
        // tone 0 alone, amplitude with bits above 12 set
        '{ROW_WRITE, REG_TONE0_AMP,  32'hFFFF_FFFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE0_STEP, 32'h4000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd16379},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, -17'sd16380},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd0},
        // all three tones at full scale: output extremes
        '{ROW_WRITE, REG_TONE1_AMP,  32'h0000_0FFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE1_STEP, 32'h4000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE2_AMP,  32'h0000_0FFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE2_STEP, 32'h4000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd49137},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, -17'sd49140},
        // writes past the register list change nothing
        '{ROW_WRITE, REG_SPARE6,     32'hFFFF_FFFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_SPARE7,     32'hFFFF_FFFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b1, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b1, 17'sd49137},
        // step extremes, amplitude written with only upper bits set
        '{ROW_WRITE, REG_TONE0_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE1_STEP, 32'h0000_0001, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE2_STEP, 32'h8000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_WRITE, REG_TONE1_AMP,  32'h0000_F000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b1, 1'b0, 17'sd0},
        '{ROW_TICK,  REG_TONE0_STEP, 32'h0000_0000, 1'b0, 1'b0, 17'sd0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       restart;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // synthesizer state
    int                         sine_lut [0:QUARTER];
    logic [STEP_W-1:0]          tone_step [TONES];
    logic [AMP_W-1:0]           tone_amp [TONES];
    logic [STEP_W-1:0]          acc_phase [TONES];

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    int                         errors = 0;
    int                         tx_mode = 1;
    int                         rx_mode = 1;

    multi_tone_sine_generator_unit #(
        .NUM_TONES      (TONES),
        .SINE_ADDR_BITS (LUT_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // (a * b) >> 62 in Q2.62
    function automatic logic [63:0] fixmul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[125:62];
    endfunction

    // One sample from the current phases, then advance them
    function automatic logic signed [SAMPLE_W-1:0] synth_sample(input logic rs);
        int                  total;
        int                  sine_val;
        int                  t;
        logic [1:0]          quad;
        logic [LUT_BITS-1:0] k;
        total = 0;
        for (t = 0; t < TONES; t++)
        begin
            if (rs)
                acc_phase[t] = '0;
            quad     = acc_phase[t][STEP_W-1:STEP_W-2];
            k        = acc_phase[t][STEP_W-3:STEP_W-2-LUT_BITS];
            sine_val = quad[0] ? sine_lut[QUARTER - int'(k)] : sine_lut[k];
            if (quad[1])
                sine_val = -sine_val;
            // arithmetic shift floors negative products
            total = total + ((int'(tone_amp[t]) * sine_val) >>> PROD_SHIFT);
            acc_phase[t] = acc_phase[t] + tone_step[t];
        end
        return total[SAMPLE_W-1:0];
    endfunction

    function automatic void load_tone_reg(input reg_index_e idx,
                                          input logic [CFG_DATA_W-1:0] data);
        logic [CFG_INDEX_W-1:0] raw;
        int                     t;
        raw = idx;
        t   = int'(raw >> 1);
        // past the list, or a tone the block does not have
        if (raw > CFG_INDEX_LAST || t >= TONES)
            return;
        if (raw[0])
            tone_amp[t] = data[AMP_W-1:0];
        else
            tone_step[t] = data;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int tx_gap();
        int roll;
        if (tx_mode == 0)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < ((tx_mode == 1) ? 70 : 40))
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Hold off the sender until every predicted sample has come out
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_e idx, input logic [CFG_DATA_W-1:0] data);
        wait_quiet();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_tone_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one tick word; the typed sample replaces the predicted one if given
    task automatic send_tick(input logic rs, input int gap, input logic typed_en,
                             input logic signed [SAMPLE_W-1:0] typed_val);
        logic signed [SAMPLE_W-1:0] predicted;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = synth_sample(rs);
        pending_samples.push_back(typed_en ? typed_val : predicted);
    endtask

    // Quarter-wave table in Q1.15 from a Taylor series in Q2.62
    initial
    begin : build_lut
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        logic [63:0] series;
        logic [63:0] scaled;
        int          k;
        int          n;
        for (k = 0; k <= QUARTER; k++)
        begin
            ang    = fixmul62(HALF_PI_Q62, 64'(k) << (62 - LUT_BITS));
            ang2   = fixmul62(ang, ang);
            term   = ang;
            series = ang;
            for (n = 1; n <= 12; n++)
            begin
                term = fixmul62(term, ang2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    series = series - term;
                else
                    series = series + term;
            end
            scaled     = ((series >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
            sine_lut[k] = int'(scaled);
        end
    end

    // Sample side stall, bursts of random length
    initial
    begin : out_backpressure
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (rx_mode != 0 && $urandom_range(0, 99) < ((rx_mode == 1) ? 15 : 40))
            begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare every accepted sample word with the oldest prediction
    always @(posedge clk)
    begin : check_samples
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t ERROR: unexpected sample word, got %0d", $time, sample);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample !== want)
                begin
                    $display("%0t ERROR: sample expected %0d, got %0d", $time, want, sample);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int                    r;
        int                    ph;
        int                    i;
        int                    w;
        int                    sel;
        logic [CFG_DATA_W-1:0] data;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (i = 0; i < TONES; i++)
        begin
            tone_step[i] = '0;
            tone_amp[i]  = '0;
            acc_phase[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            else
                send_tick(DIRECTED[r].rs, tx_gap(), DIRECTED[r].has_exp,
                          DIRECTED[r].exp_sample);
        end

        // random phases, each under its own register setting and idling mix
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            tx_mode = ph % 3;
            rx_mode = (ph + 1) % 3;
            if (ph == 0)
            begin
                // every register at full scale
                for (w = 0; w <= int'(REG_TONE2_AMP); w++)
                    write_reg(reg_index_e'(w), '1);
            end
            else if (ph == 1)
            begin
                // silent tones, random steps
                for (w = 0; w <= int'(REG_TONE2_AMP); w++)
                    write_reg(reg_index_e'(w), (w % 2 == 1) ? '0 : CFG_DATA_W'($urandom));
            end
            else
            begin
                for (w = $urandom_range(1, 6); w > 0; w--)
                begin
                    sel = $urandom_range(0, 7);
                    if (sel == 0)
                        data = '0;
                    else if (sel == 1)
                        data = '1;
                    else
                        data = $urandom;
                    write_reg(reg_index_e'($urandom_range(0, 7)), data);
                end
            end
            for (i = 0; i < TICKS_PER_PHASE; i++)
            begin
                if (ph == 4 && i == TICKS_PER_PHASE / 2)
                    wait_quiet();
                send_tick($urandom_range(0, 19) == 0, tx_gap(), 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (errors == 0 && pending_samples.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #(5_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
